// File: rtl/core/sgs_pkg.sv
// Package for the sparse Gauss-Seidel row update block.
// Holds word types, action and status codes and default sizes; no dependencies.
package sgs_pkg;

  localparam int unsigned DefVectorDepth  = 1024;
  localparam int unsigned DefFractionBits = 24;

  localparam int unsigned IdxW = 10;
  localparam int unsigned ValW = 32;
  localparam int unsigned AccW = 64;

  localparam logic [2:0] ACT_WRITE  = 3'd0;
  localparam logic [2:0] ACT_START  = 3'd1;
  localparam logic [2:0] ACT_TERM   = 3'd2;
  localparam logic [2:0] ACT_FINISH = 3'd3;
  localparam logic [2:0] ACT_READ   = 3'd4;

  localparam logic [1:0] ST_OK   = 2'd0;
  localparam logic [1:0] ST_SAT  = 2'd1;
  localparam logic [1:0] ST_ZERO = 2'd2;

  typedef struct packed {
    logic [2:0]             action;
    logic [IdxW-1:0]        index;
    logic signed [ValW-1:0] value;
    logic signed [ValW-1:0] diagonal;
  } in_word_t;

  typedef struct packed {
    logic [IdxW-1:0]        out_index;
    logic signed [ValW-1:0] out_value;
    logic [1:0]             status;
  } out_word_t;

  // divider handshake
  typedef struct packed {
    logic            start;
    logic            s_neg;
    logic            d_neg;
    logic [AccW-1:0] s_mag;
    logic [ValW-1:0] d_mag;
  } div_req_t;

  typedef struct packed {
    logic            done;
    logic [ValW-1:0] result;
    logic            sat;
  } div_rsp_t;

endpackage

// File: rtl/core/sgs_divider.sv
// Restoring radix-2 divider: 64-bit magnitude by 32-bit magnitude, one
// quotient bit a cycle, with Q.F signed saturation. Uses sgs_pkg.
module sgs_divider (
  input  logic              clk,
  input  logic              rst_n,
  input  sgs_pkg::div_req_t req,
  output sgs_pkg::div_rsp_t rsp
);
  import sgs_pkg::*;

  logic [AccW-1:0] quo_r, quo_nxt;
  logic [ValW:0]   rem_r, rem_nxt;
  logic [ValW-1:0] dmag_r;
  logic            neg_r;
  logic [6:0]      cnt_r, cnt_nxt;
  logic            busy_r, busy_nxt;
  logic            done_r;
  logic [ValW:0]   trial;
  logic [ValW:0]   diff;

  // one shift-subtract step
  always_comb begin
    trial    = {rem_r[ValW-1:0], quo_r[AccW-1]};
    diff     = trial - {1'b0, dmag_r};
    rem_nxt  = diff[ValW] ? trial : diff;
    quo_nxt  = {quo_r[AccW-2:0], ~diff[ValW]};
    cnt_nxt  = cnt_r - 7'd1;
    busy_nxt = busy_r && (cnt_r != 7'd1);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else if (req.start) begin
      busy_r <= 1'b1;
      done_r <= 1'b0;
      cnt_r  <= 7'(AccW);
    end else if (busy_r) begin
      busy_r <= busy_nxt;
      done_r <= !busy_nxt;
      cnt_r  <= cnt_nxt;
    end else begin
      done_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      quo_r  <= req.s_mag;
      rem_r  <= '0;
      dmag_r <= req.d_mag;
      neg_r  <= req.s_neg ^ req.d_neg;
    end else if (busy_r) begin
      quo_r <= quo_nxt;
      rem_r <= rem_nxt;
    end
  end

  // sign and saturate
  always_comb begin
    rsp.done = done_r;
    rsp.sat  = 1'b0;
    if (neg_r) begin
      if (quo_r > AccW'(64'h8000_0000)) begin
        rsp.sat    = 1'b1;
        rsp.result = 32'h8000_0000;
      end else begin
        rsp.result = ValW'(~quo_r + 1'b1);
      end
    end else begin
      if (quo_r > AccW'(64'h7FFF_FFFF)) begin
        rsp.sat    = 1'b1;
        rsp.result = 32'h7FFF_FFFF;
      end else begin
        rsp.result = quo_r[ValW-1:0];
      end
    end
  end

  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    busy_r |-> cnt_r <= 7'(AccW)) else $error("divider count overrun");
  a_done_pulse: assert property (@(posedge clk) disable iff (!rst_n)
    done_r |=> !done_r) else $error("divider done held");
  a_done_follows: assert property (@(posedge clk) disable iff (!rst_n)
    done_r |-> $past(busy_r)) else $error("divider done without work");

endmodule

// File: rtl/core/sparse_gauss_seidel_row_update.sv
// Sparse Gauss-Seidel row update engine: top level with the x memory,
// row accumulator and sequencer. Uses sgs_pkg and sgs_divider.
//
// The solution vector x lives in a one-port-read, one-port-write synchronous
// memory of VECTOR_DEPTH words. Write x and start row are done as the word is
// accepted. Add term goes through memory read, multiply and accumulate, and
// read x through memory read, staging and output load. Finish row goes through
// x[row] read, product, sum, the 64-step bit-serial divider and output load;
// with a zero diagonal it skips the divider. One word is in work at a
// time; a result waits in the output register while the next word is
// accepted, and that word only stalls in its output step while the result
// ahead of it is still held. Entries of x hold nothing until written; indexes
// at or past VECTOR_DEPTH read as zero and are not written.
module sparse_gauss_seidel_row_update #(
  parameter int unsigned VECTOR_DEPTH  = sgs_pkg::DefVectorDepth,
  parameter int unsigned FRACTION_BITS = sgs_pkg::DefFractionBits
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  sgs_pkg::in_word_t  in_data,
  output logic               out_valid,
  input  logic               out_stall,
  output sgs_pkg::out_word_t out_data
);
  import sgs_pkg::*;

  localparam int unsigned AW = (VECTOR_DEPTH > 1) ? $clog2(VECTOR_DEPTH) : 1;

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_RD   = 3'd1;
  localparam logic [2:0] S_MUL  = 3'd2;
  localparam logic [2:0] S_SUM  = 3'd3;
  localparam logic [2:0] S_DIV  = 3'd4;
  localparam logic [2:0] S_OUT  = 3'd5;

  logic [ValW-1:0] x_mem [VECTOR_DEPTH];
  logic [ValW-1:0] rd_data_r;
  logic            rd_ok_r;

  logic [2:0]             state_r;
  logic [2:0]             act_r;
  logic [IdxW-1:0]        idx_r;
  logic signed [ValW-1:0] val_r;
  logic signed [AccW-1:0] row_sum_r;
  logic [IdxW-1:0]        open_row_r;
  logic signed [ValW-1:0] open_diag_r;
  logic signed [AccW-1:0] prod_r;
  logic [ValW-1:0]        xr_r;
  logic                   out_valid_r;
  out_word_t              out_r;
  out_word_t              res_r;

  logic            accept;
  logic [IdxW-1:0] rd_idx;
  logic            rd_en;
  logic            rd_in_range;
  logic [ValW-1:0] x_rd;
  logic signed [AccW-1:0] s_sum;
  logic            wr_en;
  logic [IdxW-1:0] wr_idx;
  logic [ValW-1:0] wr_val;
  div_req_t        dreq;
  div_rsp_t        drsp;

  assign in_stall  = (state_r != S_IDLE);
  assign accept    = in_valid && !in_stall;
  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  // memory read address: new word's index, or the open row on finish
  assign rd_idx = (in_data.action == ACT_FINISH) ? open_row_r : in_data.index;
  assign rd_en  = accept && (in_data.action == ACT_TERM || in_data.action == ACT_READ
                  || in_data.action == ACT_FINISH);
  assign rd_in_range = 32'(rd_idx) < VECTOR_DEPTH;
  assign x_rd = rd_ok_r ? rd_data_r : '0;

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= x_mem[AW'(rd_idx)];
      rd_ok_r   <= rd_in_range;
    end
    if (wr_en) x_mem[AW'(wr_idx)] <= wr_val;
  end

  // memory writes
  always_comb begin
    wr_en  = 1'b0;
    wr_idx = in_data.index;
    wr_val = in_data.value;
    if (accept && in_data.action == ACT_WRITE) begin
      wr_en = 32'(in_data.index) < VECTOR_DEPTH;
    end else if (state_r == S_DIV && drsp.done) begin
      wr_idx = open_row_r;
      wr_val = drsp.result;
      wr_en  = 32'(open_row_r) < VECTOR_DEPTH;
    end
  end

  assign s_sum = row_sum_r + prod_r;

  // divider request from the completed sum
  always_comb begin
    dreq.start = (state_r == S_SUM) && (open_diag_r != '0);
    dreq.s_neg = s_sum[AccW-1];
    dreq.d_neg = open_diag_r[ValW-1];
    dreq.s_mag = s_sum[AccW-1] ? AccW'(-s_sum) : AccW'(s_sum);
    dreq.d_mag = open_diag_r[ValW-1] ? ValW'(-open_diag_r) : ValW'(open_diag_r);
  end

  sgs_divider u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (dreq),
    .rsp   (drsp)
  );

  // sequencer
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
      row_sum_r   <= '0;
      open_row_r  <= '0;
      open_diag_r <= '0;
    end else begin
      // output register: load the staged word once the previous one has left
      if (state_r == S_OUT && (!out_valid_r || !out_stall)) begin
        out_r       <= res_r;
        out_valid_r <= 1'b1;
      end else if (out_valid_r && !out_stall) begin
        out_valid_r <= 1'b0;
      end
      case (state_r)
        S_IDLE: begin
          if (accept) begin
            act_r <= in_data.action;
            idx_r <= in_data.index;
            val_r <= in_data.value;
            case (in_data.action)
              ACT_START: begin
                open_row_r  <= in_data.index;
                open_diag_r <= in_data.diagonal;
                row_sum_r   <= AccW'(signed'(in_data.value)) <<< FRACTION_BITS;
              end
              ACT_TERM, ACT_READ, ACT_FINISH: state_r <= S_RD;
              default: ;
            endcase
          end
        end
        S_RD: begin
          xr_r <= x_rd;
          if (act_r == ACT_READ) begin
            res_r   <= '{out_index: idx_r, out_value: x_rd, status: ST_OK};
            state_r <= S_OUT;
          end else if (act_r == ACT_TERM) begin
            prod_r  <= AccW'(val_r) * AccW'(signed'(x_rd));
            state_r <= S_MUL;
          end else begin
            prod_r  <= AccW'(signed'(x_rd)) * AccW'(open_diag_r);
            state_r <= S_SUM;
          end
        end
        S_MUL: begin
          row_sum_r <= row_sum_r - prod_r;
          state_r   <= S_IDLE;
        end
        S_SUM: begin
          if (open_diag_r == '0) begin
            res_r   <= '{out_index: open_row_r, out_value: xr_r, status: ST_ZERO};
            state_r <= S_OUT;
          end else begin
            state_r <= S_DIV;
          end
        end
        S_DIV: begin
          if (drsp.done) begin
            res_r   <= '{out_index: open_row_r, out_value: drsp.result,
                         status: drsp.sat ? ST_SAT : ST_OK};
            state_r <= S_OUT;
          end
        end
        S_OUT: begin
          if (!out_valid_r || !out_stall) begin
            state_r <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r != S_IDLE) |-> in_stall) else $error("word accepted while busy");
  a_div_only: assert property (@(posedge clk) disable iff (!rst_n)
    drsp.done |-> state_r == S_DIV) else $error("divider result out of place");
  a_zero_nodiv: assert property (@(posedge clk) disable iff (!rst_n)
    dreq.start |-> open_diag_r != '0) else $error("divide by zero started");
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_stall) |=> out_valid_r && $stable(out_r))
    else $error("result lost while stalled");

endmodule

// File: tb/sv/sgs_checker.sv
// Checker for the sparse Gauss-Seidel row update block: watches both
// channels, predicts each result word and compares it. Uses sgs_pkg.
module sgs_checker (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  input  logic               in_stall,
  input  sgs_pkg::in_word_t  in_data,
  input  logic               out_valid,
  input  logic               out_stall,
  input  sgs_pkg::out_word_t out_data,
  output int                 fail_count,
  output int                 pending_count
);
  import sgs_pkg::*;

  localparam int Frac = DefFractionBits;

  logic [ValW-1:0] x_model [DefVectorDepth];
  logic [AccW-1:0] sum_model;
  logic [IdxW-1:0] row_model;
  logic [ValW-1:0] diag_model;
  out_word_t       expected_words [$];

  assign pending_count = expected_words.size();

  // next x[row] from the open row state
  function automatic out_word_t finish_row_word();
    out_word_t       w;
    logic [ValW-1:0] xr;
    logic [AccW-1:0] s, smag, dmag, q;
    logic            sneg, dneg;
    xr = x_model[row_model];
    w.out_index = row_model;
    if (diag_model == '0) begin
      w.out_value = xr;
      w.status    = ST_ZERO;
      return w;
    end
    s    = sum_model + (AccW'($signed(xr)) * AccW'($signed(diag_model)));
    sneg = s[AccW-1];
    smag = sneg ? -s : s;
    dneg = diag_model[ValW-1];
    dmag = dneg ? {32'd0, -diag_model} : {32'd0, diag_model};
    if (dmag == 0) dmag = 64'h8000_0000;
    q = smag / dmag;
    w.status = ST_OK;
    if (sneg != dneg) begin
      if (q > 64'h8000_0000) begin
        q = 64'h8000_0000;
        w.status = ST_SAT;
      end
      w.out_value = -q[ValW-1:0];
    end else begin
      if (q > 64'h7FFF_FFFF) begin
        q = 64'h7FFF_FFFF;
        w.status = ST_SAT;
      end
      w.out_value = q[ValW-1:0];
    end
    x_model[row_model] = w.out_value;
    return w;
  endfunction

  always @(posedge clk) begin
    if (!rst_n) begin
      sum_model  <= '0;
      row_model  <= '0;
      diag_model <= '0;
      fail_count = 0;
      expected_words.delete();
    end else begin
      // result side: compare with the oldest prediction
      if (out_valid && !out_stall) begin
        if (expected_words.size() == 0) begin
          $error("unexpected result word idx=%0d", out_data.out_index);
          fail_count = fail_count + 1;
        end else begin
          out_word_t e;
          e = expected_words.pop_front();
          if (out_data.out_index !== e.out_index) begin
            $error("out_index exp %0d got %0d", e.out_index, out_data.out_index);
            fail_count = fail_count + 1;
          end
          if (out_data.out_value !== e.out_value) begin
            $error("out_value exp %h got %h", e.out_value, out_data.out_value);
            fail_count = fail_count + 1;
          end
          if (out_data.status !== e.status) begin
            $error("status exp %0d got %0d", e.status, out_data.status);
            fail_count = fail_count + 1;
          end
        end
      end
      // input side: advance the model
      if (in_valid && !in_stall) begin
        out_word_t w;
        case (in_data.action)
          ACT_WRITE: x_model[in_data.index] = in_data.value;
          ACT_START: begin
            row_model  <= in_data.index;
            diag_model <= in_data.diagonal;
            sum_model  <= AccW'($signed(in_data.value)) << Frac;
          end
          ACT_TERM: sum_model <= sum_model
            - (AccW'($signed(in_data.value)) * AccW'($signed(x_model[in_data.index])));
          ACT_FINISH: begin
            w = finish_row_word();
            expected_words.push_back(w);
          end
          ACT_READ: begin
            w.out_index = in_data.index;
            w.out_value = x_model[in_data.index];
            w.status    = ST_OK;
            expected_words.push_back(w);
          end
          default: ;
        endcase
      end
    end
  end
endmodule

// File: tb/sv/tb_top.sv
// Testbench top for sparse_gauss_seidel_row_update: drives words, random
// idling and back-pressure, and gives the verdict. Uses sgs_pkg, sgs_checker.
module tb_top;
  import sgs_pkg::*;

  logic      clk = 0;
  logic      rst_n = 0;
  logic      in_valid = 0;
  logic      in_stall;
  in_word_t  in_data = '0;
  logic      out_valid;
  logic      out_stall = 0;
  out_word_t out_data;
  int        fail_count, pending_count;
  bit        quiet = 0;
  bit        hold_off = 0;
  bit        written [DefVectorDepth];
  int        word_count = 0;

  sparse_gauss_seidel_row_update dut (
    .clk, .rst_n, .in_valid, .in_stall, .in_data, .out_valid, .out_stall, .out_data
  );

  sgs_checker chk (
    .clk, .rst_n, .in_valid, .in_stall, .in_data, .out_valid, .out_stall, .out_data,
    .fail_count, .pending_count
  );

  always begin
    #4 clk = 1;
    #4 clk = 0;
  end

  // offer one word and wait for its acceptance, with a random gap before it
  task automatic send_word(input logic [2:0] act, input logic [IdxW-1:0] idx,
                           input logic [ValW-1:0] val, input logic [ValW-1:0] diag);
    int gap;
    gap = (!quiet && $urandom_range(3) == 0) ? $urandom_range(1, 3) : 0;
    if (gap > 0) begin
      in_valid <= 0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1;
    in_data  <= '{action: act, index: idx, value: val, diagonal: diag};
    @(posedge clk);
    while (in_stall) @(posedge clk);
    if (act == ACT_WRITE) written[idx] = 1;
    word_count++;
  endtask

  function automatic logic [ValW-1:0] rand_value();
    case ($urandom_range(5))
      0: return 32'h8000_0000;
      1: return 32'h7FFF_FFFF;
      2: return 32'($signed($urandom_range(0, 32'h0200_0000)) - 32'sh0100_0000);
      default: return $urandom;
    endcase
  endfunction

  function automatic logic [IdxW-1:0] rand_written();
    logic [IdxW-1:0] i;
    do i = IdxW'($urandom_range(63)); while (!written[i]);
    return i;
  endfunction

  // a well-formed row over written entries
  task automatic send_row();
    logic [IdxW-1:0] r;
    r = rand_written();
    send_word(ACT_START, r, rand_value(),
              ($urandom_range(15) == 0) ? 32'd0 : rand_value());
    repeat ($urandom_range(0, 6)) send_word(ACT_TERM, rand_written(), rand_value(), $urandom);
    send_word(ACT_FINISH, IdxW'($urandom), $urandom, $urandom);
  endtask

  // receiver: random stall bursts, one long hold-off on request
  initial begin
    forever begin
      @(posedge clk);
      if (hold_off) begin
        out_stall <= 1;
        repeat (300) @(posedge clk);
        hold_off = 0;
        out_stall <= 0;
      end else if (!quiet && $urandom_range(3) == 0) begin
        out_stall <= 1;
        repeat ($urandom_range(1, 3)) @(posedge clk);
        out_stall <= 0;
      end
    end
  end

  initial begin
    repeat (6) @(posedge clk);
    rst_n <= 1;
    @(posedge clk);
    // directed: extremes, every action, zero diagonal, saturation, bad code
    send_word(ACT_WRITE, 10'd0, 32'h8000_0000, 0);
    send_word(ACT_WRITE, 10'd1023, 32'h7FFF_FFFF, 0);
    send_word(ACT_WRITE, 10'd1, 32'h0100_0000, 0);
    send_word(ACT_READ, 10'd0, 0, 0);
    send_word(ACT_READ, 10'd1023, 0, 0);
    send_word(ACT_FINISH, 10'd0, 0, 0);
    send_word(ACT_START, 10'd1, 32'h0200_0000, 32'h0100_0000);
    send_word(ACT_TERM, 10'd1023, 32'h7FFF_FFFF, 0);
    send_word(ACT_TERM, 10'd0, 32'h8000_0000, 0);
    send_word(ACT_FINISH, 10'd0, 0, 0);
    send_word(ACT_START, 10'd1, 32'h7FFF_FFFF, 32'h0000_0001);
    send_word(ACT_FINISH, 10'd0, 0, 0);
    send_word(ACT_START, 10'd1023, 32'h8000_0000, 32'h8000_0000);
    send_word(ACT_FINISH, 10'd0, 0, 0);
    send_word(ACT_START, 10'd0, 32'h7FFF_FFFF, 32'hFFFF_FFFF);
    send_word(ACT_FINISH, 10'd0, 0, 0);
    send_word(ACT_START, 10'd1, $urandom, 32'd0);
    send_word(ACT_FINISH, 10'd0, 0, 0);
    send_word(3'd5, 10'd3, $urandom, $urandom);
    send_word(3'd7, 10'd1023, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    send_word(ACT_READ, 10'd1, 0, 0);
    for (int i = 0; i < 64; i++) send_word(ACT_WRITE, i[IdxW-1:0], rand_value(), 0);
    // sender pauses until every result is in
    in_valid <= 0;
    @(posedge clk);
    while (pending_count != 0) @(posedge clk);
    // long receiver hold-off while words keep coming
    hold_off = 1;
    for (int i = 0; i < 20; i++) send_word(ACT_READ, rand_written(), 0, 0);
    // random part
    while (word_count < 950) begin
      if (word_count > 860) quiet = 1;
      case ($urandom_range(9))
        0: send_word(ACT_WRITE, IdxW'($urandom), rand_value(), $urandom);
        1: send_word(ACT_READ, rand_written(), $urandom, $urandom);
        2: send_word(3'($urandom_range(5, 7)), IdxW'($urandom), $urandom, $urandom);
        default: send_row();
      endcase
    end
    in_valid <= 0;
    @(posedge clk);
    while (pending_count != 0) @(posedge clk);
    repeat (100) @(posedge clk);
    if (fail_count == 0 && pending_count == 0) $display("tb_top: done, clean");
    else $display("tb_top: done, errors");
    $finish;
  end

  // run limit
  initial begin
    #2000000;
    $display("tb_top: done, errors");
    $finish;
  end
endmodule
